@@ rtl/led_fade_stepper_top_macros.svh @@
// Assertion macros used by the RTL of the LED fade stepper.
// Synthesis builds define SYNTH and get empty bodies.
`ifndef LED_FADE_STEPPER_TOP_MACROS_SVH
`define LED_FADE_STEPPER_TOP_MACROS_SVH

`ifndef SYNTH

// a in one cycle implies b in the same cycle
`define LFS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("led_fade_stepper: assertion failed");

// a in one cycle implies b in the next cycle
`define LFS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("led_fade_stepper: assertion failed");

`else

`define LFS_ASSERT_SAME(label, clk, rst, a, b)
`define LFS_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

@@ rtl/lfs_pkg.sv @@
`default_nettype none

package lfs_pkg;

   // transaction payload widths (whole bytes) and configuration port widths
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_UP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_DOWN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_COLOR = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HAS_WHITE  = 2'd3;

   // tick counter slots
   localparam int CNT_UP    = 0;
   localparam int CNT_DOWN  = 1;
   localparam int CNT_COLOR = 2;
   localparam int CNT_NUM   = 3;

   // fade step constants
   localparam logic [15:0] KELVIN_STEP  = 16'd20;
   localparam logic [7:0]  HUE_HALF     = 8'd128;
   localparam logic [7:0]  SAT_DIP_DIST = 8'd43;
   localparam logic [7:0]  SAT_DIP_STEP = 8'd2;

endpackage

`default_nettype wire

@@ rtl/led_fade_stepper_top.sv @@
// LED fade stepper. Every request transaction is one fade tick: it may load new
// brightness, hue, saturation and kelvin targets, then steps the actual values
// toward them as the three interval counters (up, down, color) allow. The tick is
// captured in the input register at the accepting edge, and one pass of step logic
// then writes the result register as soon as that register is free or drained.
// A new tick is accepted every cycle while the receiver takes results; throughput is
// one tick per cycle, set by the state update loop. While a result waits, the input
// register takes one more tick; after that req_tready follows rsp_tready.
// Configuration writes take effect at once and should be made while no tick is in
// flight.
`default_nettype none

`include "led_fade_stepper_top_macros.svh"

module led_fade_stepper_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [lfs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [lfs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // tick requests
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [0] load_targets, [8:1] target_brightness, [16:9] target_hue,
   // [24:17] target_saturation, [40:25] target_kelvin, [41] cct_mode,
   // [42] relative_active, [47:43] zero
   input  wire logic [lfs_pkg::REQ_DATA_W-1:0]       req_tdata,
   // tick results
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [7:0] level_now, [15:8] value_now, [23:16] hue_now,
   // [31:24] saturation_now, [47:32] kelvin_now, [48] drive_changed,
   // [49] onoff_changed, [55:50] zero
   output logic [lfs_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   // configuration registers
   logic [7:0] fade_up_ff, fade_down_ff, fade_color_ff;
   logic       has_white_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_up_ff    <= '0;
         fade_down_ff  <= '0;
         fade_color_ff <= '0;
         has_white_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            lfs_pkg::REG_FADE_UP:    fade_up_ff    <= csr_wdata;
            lfs_pkg::REG_FADE_DOWN:  fade_down_ff  <= csr_wdata;
            lfs_pkg::REG_FADE_COLOR: fade_color_ff <= csr_wdata;
            lfs_pkg::REG_HAS_WHITE:  has_white_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic                              s1_valid_ff;
   logic [lfs_pkg::REQ_DATA_W-1:0]    s1_data_ff;
   logic                              rsp_valid_ff;
   logic [lfs_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic                              advance;
   logic                              take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign take       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
   end

   // fade state
   logic [7:0]  goal_level_ff, goal_hue_ff, goal_sat_ff;
   logic [15:0] goal_kelvin_ff;
   logic [7:0]  act_level_ff, act_value_ff, act_hue_ff, act_sat_ff;
   logic [15:0] act_kelvin_ff;
   logic [7:0]  cnt_ff [lfs_pkg::CNT_NUM];

   logic [7:0]  goal_level_in, goal_hue_in, goal_sat_in;
   logic [15:0] goal_kelvin_in;
   logic [7:0]  act_level_in, act_value_in, act_hue_in, act_sat_in;
   logic [15:0] act_kelvin_in;
   logic [7:0]  cnt_in [lfs_pkg::CNT_NUM];
   logic        drive_in, onoff_in;

   // tick fields
   logic        f_load, f_cct, f_rel;
   logic [7:0]  f_bright, f_hue, f_sat;
   logic [15:0] f_kelvin;

   assign f_load   = s1_data_ff[0];
   assign f_bright = s1_data_ff[8:1];
   assign f_hue    = s1_data_ff[16:9];
   assign f_sat    = s1_data_ff[24:17];
   assign f_kelvin = s1_data_ff[40:25];
   assign f_cct    = s1_data_ff[41];
   assign f_rel    = s1_data_ff[42];

   // step logic
   always_comb begin
      logic [7:0]        intv [lfs_pkg::CNT_NUM];
      logic [7:0]        inc;
      logic [lfs_pkg::CNT_NUM-1:0] go;
      logic              up, down, color;
      logic [15:0]       kdiff;
      logic [7:0]        hdist;
      logic              hwrap;
      logic signed [9:0] sdiff;
      logic signed [9:0] hdist_s;

      intv[lfs_pkg::CNT_UP]    = fade_up_ff;
      intv[lfs_pkg::CNT_DOWN]  = fade_down_ff;
      intv[lfs_pkg::CNT_COLOR] = fade_color_ff;

      // goals, optionally replaced before stepping
      goal_level_in  = f_load ? f_bright : goal_level_ff;
      goal_hue_in    = f_load ? f_hue    : goal_hue_ff;
      goal_sat_in    = f_load ? f_sat    : goal_sat_ff;
      goal_kelvin_in = f_load ? f_kelvin : goal_kelvin_ff;

      // interval counters; a permitted step clears its counter
      for (int i = 0; i < lfs_pkg::CNT_NUM; i++) begin
         inc       = cnt_ff[i] + 8'd1;
         go[i]     = (inc >= intv[i]) || f_rel;
         cnt_in[i] = go[i] ? 8'd0 : inc;
      end
      up    = go[lfs_pkg::CNT_UP];
      down  = go[lfs_pkg::CNT_DOWN];
      color = go[lfs_pkg::CNT_COLOR];

      drive_in = 1'b0;

      // brightness
      act_level_in = act_level_ff;
      if (goal_level_in > act_level_ff && up) begin
         act_level_in = act_level_ff + 8'd1;
         drive_in     = 1'b1;
      end else if (goal_level_in < act_level_ff && down) begin
         act_level_in = act_level_ff - 8'd1;
         drive_in     = 1'b1;
      end
      onoff_in = (act_level_in == 8'd0) != (act_level_ff == 8'd0);

      // HSV value: drains to zero in white temperature mode with white channels
      act_value_in = act_value_ff;
      if (f_cct && has_white_ff) begin
         if (act_value_ff != 8'd0 && down) begin
            act_value_in = act_value_ff - 8'd1;
            drive_in     = 1'b1;
         end
      end else if (goal_level_in > act_value_ff && up) begin
         act_value_in = act_value_ff + 8'd1;
         drive_in     = 1'b1;
      end else if (goal_level_in < act_value_ff && down) begin
         act_value_in = act_value_ff - 8'd1;
         drive_in     = 1'b1;
      end

      act_kelvin_in = act_kelvin_ff;
      act_hue_in    = act_hue_ff;
      act_sat_in    = act_sat_ff;
      kdiff         = '0;
      hdist         = '0;
      hwrap         = 1'b0;
      sdiff         = '0;
      hdist_s       = '0;

      if (color) begin
         // kelvin: fixed steps, clamped at the goal
         if (goal_kelvin_in > act_kelvin_ff) begin
            kdiff         = goal_kelvin_in - act_kelvin_ff;
            act_kelvin_in = (kdiff > lfs_pkg::KELVIN_STEP) ?
                            act_kelvin_ff + lfs_pkg::KELVIN_STEP : goal_kelvin_in;
            drive_in      = 1'b1;
         end else if (goal_kelvin_in < act_kelvin_ff) begin
            kdiff         = act_kelvin_ff - goal_kelvin_in;
            act_kelvin_in = (kdiff > lfs_pkg::KELVIN_STEP) ?
                            act_kelvin_ff - lfs_pkg::KELVIN_STEP : goal_kelvin_in;
            drive_in      = 1'b1;
         end

         // hue: shorter way round, direct way at exactly half a turn
         hdist = (goal_hue_in > act_hue_ff) ? goal_hue_in - act_hue_ff
                                            : act_hue_ff - goal_hue_in;
         hwrap = hdist > lfs_pkg::HUE_HALF;
         if (hdist != 8'd0) begin
            act_hue_in = ((goal_hue_in > act_hue_ff) != hwrap) ?
                         act_hue_ff + 8'd1 : act_hue_ff - 8'd1;
            drive_in   = 1'b1;
         end

         // saturation: dips during large hue moves, else one step to goal
         sdiff   = $signed({2'b00, goal_sat_in}) - $signed({2'b00, act_sat_ff});
         hdist_s = $signed({2'b00, hdist});
         if (hdist > lfs_pkg::SAT_DIP_DIST && sdiff < hdist_s && act_sat_ff > 8'd1) begin
            act_sat_in = act_sat_ff - lfs_pkg::SAT_DIP_STEP;
            drive_in   = 1'b1;
         end else if (goal_sat_in != act_sat_ff) begin
            act_sat_in = (goal_sat_in > act_sat_ff) ? act_sat_ff + 8'd1
                                                    : act_sat_ff - 8'd1;
            drive_in   = 1'b1;
         end
      end
   end

   // state update, one tick per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_level_ff  <= '0;
         goal_hue_ff    <= '0;
         goal_sat_ff    <= '0;
         goal_kelvin_ff <= '0;
         act_level_ff   <= '0;
         act_value_ff   <= '0;
         act_hue_ff     <= '0;
         act_sat_ff     <= '0;
         act_kelvin_ff  <= '0;
         for (int i = 0; i < lfs_pkg::CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (take) begin
         goal_level_ff  <= goal_level_in;
         goal_hue_ff    <= goal_hue_in;
         goal_sat_ff    <= goal_sat_in;
         goal_kelvin_ff <= goal_kelvin_in;
         act_level_ff   <= act_level_in;
         act_value_ff   <= act_value_in;
         act_hue_ff     <= act_hue_in;
         act_sat_ff     <= act_sat_in;
         act_kelvin_ff  <= act_kelvin_in;
         for (int i = 0; i < lfs_pkg::CNT_NUM; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= {6'd0, onoff_in, drive_in, act_kelvin_in, act_sat_in,
                         act_hue_in, act_value_in, act_level_in};
      end
   end

   // an accepted transaction lands in the input register
   `LFS_ASSERT_NEXT(a_req_enters_s1, clock, reset, req_tvalid && req_tready, s1_valid_ff)

   // fade state only moves when a tick is processed
   `LFS_ASSERT_NEXT(a_state_idle_hold, clock, reset, !take,
      $stable(act_level_ff) && $stable(act_kelvin_ff) && $stable(act_hue_ff))

   // brightness moves by at most one per tick
   `LFS_ASSERT_NEXT(a_level_unit_step, clock, reset, take,
      (act_level_ff == $past(act_level_ff)) ||
      (act_level_ff == $past(act_level_ff) + 8'd1) ||
      (act_level_ff == $past(act_level_ff) - 8'd1))

   // the result mirrors the state it was computed into
   `LFS_ASSERT_NEXT(a_rsp_matches_state, clock, reset, take,
      rsp_valid_ff && (rsp_data_ff[7:0] == act_level_ff) &&
      (rsp_data_ff[47:32] == act_kelvin_ff))

endmodule

`default_nettype wire

@@ sim/led_fade_stepper_top_tb.sv @@
`timescale 1ns / 1ps

module led_fade_stepper_top_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PRESSURE_HOLD  = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int KELVIN_MAX     = 40000;

   // one tick request
   typedef struct {
      bit        load;
      bit [7:0]  bright;
      bit [7:0]  hue;
      bit [7:0]  sat;
      bit [15:0] kelvin;
      bit        cct;
      bit        rel;
   } tick_type;

   // actual values reported after one tick
   typedef struct {
      bit [7:0]  level;
      bit [7:0]  value;
      bit [7:0]  hue;
      bit [7:0]  sat;
      bit [15:0] kelvin;
      bit        drive;
      bit        onoff;
   } fade_state_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [lfs_pkg::CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [lfs_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [lfs_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lfs_pkg::RSP_DATA_W-1:0]   rsp_tdata;

   // fade predictor: configuration copy and state
   bit [7:0]  cfg_up, cfg_down, cfg_color;
   bit        cfg_white;
   bit [7:0]  tgt_level, tgt_hue, tgt_sat;
   bit [15:0] tgt_kelvin;
   bit [7:0]  cur_level, cur_value, cur_hue, cur_sat;
   bit [15:0] cur_kelvin;
   bit [7:0]  interval_cnt [lfs_pkg::CNT_NUM];

   fade_state_type fade_expect [$];
   int          fail_count   = 0;
   int          stall_cycles = 0;
   int          rsp_hold     = 0;
   int          rsp_gap      = 0;
   bit          req_steady   = 1'b0;
   bit          rsp_steady   = 1'b0;

   led_fade_stepper_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // interval counter: bump, then permit and clear at or past the interval
   function automatic bit take_step(input int slot, input bit [7:0] interval,
                                    input bit forced);
      interval_cnt[slot] = interval_cnt[slot] + 8'd1;
      if (interval_cnt[slot] >= interval || forced) begin
         interval_cnt[slot] = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // one fade tick of the predictor
   function automatic fade_state_type advance_fade(input tick_type t);
      fade_state_type r;
      bit          up_ok, down_ok, color_ok, wrap;
      bit [7:0]    old_level;
      int          k, dh, ds, hue_dist;
      r.drive = 1'b0;
      if (t.load) begin
         tgt_level  = t.bright;
         tgt_hue    = t.hue;
         tgt_sat    = t.sat;
         tgt_kelvin = t.kelvin;
      end
      up_ok    = take_step(lfs_pkg::CNT_UP, cfg_up, t.rel);
      down_ok  = take_step(lfs_pkg::CNT_DOWN, cfg_down, t.rel);
      color_ok = take_step(lfs_pkg::CNT_COLOR, cfg_color, t.rel);

      // brightness
      old_level = cur_level;
      if (tgt_level > cur_level && up_ok) begin
         cur_level = cur_level + 8'd1;
         r.drive = 1'b1;
      end else if (tgt_level < cur_level && down_ok) begin
         cur_level = cur_level - 8'd1;
         r.drive = 1'b1;
      end
      r.onoff = (cur_level == 0) != (old_level == 0);

      // HSV value, drained in white mode
      if (t.cct && cfg_white) begin
         if (cur_value > 0 && down_ok) begin
            cur_value = cur_value - 8'd1;
            r.drive = 1'b1;
         end
      end else if (tgt_level > cur_value && up_ok) begin
         cur_value = cur_value + 8'd1;
         r.drive = 1'b1;
      end else if (tgt_level < cur_value && down_ok) begin
         cur_value = cur_value - 8'd1;
         r.drive = 1'b1;
      end

      if (color_ok) begin
         // kelvin, clamped at the goal
         if (tgt_kelvin > cur_kelvin) begin
            k = int'(cur_kelvin) + int'(lfs_pkg::KELVIN_STEP);
            cur_kelvin = (k < int'(tgt_kelvin)) ? k[15:0] : tgt_kelvin;
            r.drive = 1'b1;
         end else if (tgt_kelvin < cur_kelvin) begin
            k = int'(cur_kelvin) - int'(lfs_pkg::KELVIN_STEP);
            cur_kelvin = (k > int'(tgt_kelvin)) ? k[15:0] : tgt_kelvin;
            r.drive = 1'b1;
         end

         // hue along the shorter arc; half circle goes the direct way
         dh       = int'(tgt_hue) - int'(cur_hue);
         hue_dist = (dh < 0) ? -dh : dh;
         if (hue_dist > 0) begin
            wrap = hue_dist > int'(lfs_pkg::HUE_HALF);
            if ((tgt_hue > cur_hue) != wrap) cur_hue = cur_hue + 8'd1;
            else cur_hue = cur_hue - 8'd1;
            r.drive = 1'b1;
         end

         // saturation, dipped during large hue moves
         ds = int'(tgt_sat) - int'(cur_sat);
         if (hue_dist > int'(lfs_pkg::SAT_DIP_DIST) && ds < hue_dist && cur_sat > 1) begin
            cur_sat = cur_sat - lfs_pkg::SAT_DIP_STEP;
            r.drive = 1'b1;
         end else if (tgt_sat != cur_sat) begin
            if (tgt_sat > cur_sat) cur_sat = cur_sat + 8'd1;
            else cur_sat = cur_sat - 8'd1;
            r.drive = 1'b1;
         end
      end

      r.level  = cur_level;
      r.value  = cur_value;
      r.hue    = cur_hue;
      r.sat    = cur_sat;
      r.kelvin = cur_kelvin;
      return r;
   endfunction

   function automatic tick_type make_tick(input bit load, input bit [7:0] bright,
                                          input bit [7:0] hue, input bit [7:0] sat,
                                          input bit [15:0] kelvin, input bit cct,
                                          input bit rel);
      tick_type t;
      t.load   = load;
      t.bright = bright;
      t.hue    = hue;
      t.sat    = sat;
      t.kelvin = kelvin;
      t.cct    = cct;
      t.rel    = rel;
      return t;
   endfunction

   function automatic tick_type random_tick();
      return make_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, KELVIN_MAX)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
   endfunction

   // tick without a target load; the ignored fields carry random content
   function automatic tick_type idle_tick(input bit cct, input bit rel);
      tick_type t;
      t      = random_tick();
      t.load = 1'b0;
      t.cct  = cct;
      t.rel  = rel;
      return t;
   endfunction

   // realistic tick: rare loads, often with targets close to the actual values
   function automatic tick_type shaped_tick();
      tick_type t;
      int       k;
      bit [7:0] hue_off;
      t      = random_tick();
      t.load = $urandom_range(0, 99) < 15;
      t.rel  = $urandom_range(0, 99) < 8;
      t.cct  = $urandom_range(0, 99) < 35;
      if (t.load && $urandom_range(0, 1)) begin
         case ($urandom_range(0, 4))
            0: hue_off = 8'd128;
            1: hue_off = 8'd43;
            2: hue_off = 8'd44;
            3: hue_off = 8'd213;
            default: hue_off = 8'($urandom_range(0, 8));
         endcase
         t.hue    = cur_hue + hue_off;
         t.bright = cur_level + 8'($urandom_range(0, 6)) - 8'd3;
         t.sat    = cur_sat + 8'($urandom_range(0, 6)) - 8'd3;
         k = int'(cur_kelvin) + int'($urandom_range(0, 120)) - 60;
         if (k < 0) k = 0;
         if (k > KELVIN_MAX) k = KELVIN_MAX;
         t.kelvin = k[15:0];
      end
      return t;
   endfunction

   // offer one tick, predict it once the transaction completes
   task automatic send_tick(input tick_type t);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'b0, t.rel, t.cct, t.kelvin, t.sat, t.hue, t.bright, t.load};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fade_expect.push_back(advance_fade(t));
   endtask

   // stop offering, wait for all results and let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (fade_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic set_config(input bit [7:0] up, input bit [7:0] down,
                             input bit [7:0] color, input bit white);
      csr_we    <= 1'b1;
      csr_index <= lfs_pkg::REG_FADE_UP;
      csr_wdata <= up;
      @(posedge clock);
      csr_index <= lfs_pkg::REG_FADE_DOWN;
      csr_wdata <= down;
      @(posedge clock);
      csr_index <= lfs_pkg::REG_FADE_COLOR;
      csr_wdata <= color;
      @(posedge clock);
      csr_index <= lfs_pkg::REG_HAS_WHITE;
      csr_wdata <= {7'b0, white};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_up    = up;
      cfg_down  = down;
      cfg_color = color;
      cfg_white = white;
   endtask

   // reset intervals: full-scale targets, hue wrap, half-circle hue, dip, clamps
   task automatic test_full_range();
      send_tick(make_tick(1'b1, 8'd255, 8'd200, 8'd255, 16'(KELVIN_MAX), 1'b0, 1'b0));
      send_tick(idle_tick(1'b0, 1'b0));
      send_tick(make_tick(1'b1, 8'd0, cur_hue + lfs_pkg::HUE_HALF, 8'd0, 16'd0,
                          1'b0, 1'b0));
      send_tick(idle_tick(1'b0, 1'b0));
      send_tick(idle_tick(1'b0, 1'b0));
      send_tick(make_tick(1'b1, 8'd1, 8'd0, 8'd0, cur_kelvin + 16'd7, 1'b0, 1'b0));
      send_tick(idle_tick(1'b0, 1'b0));
      send_tick(make_tick(1'b1, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0));
      wait_idle();
   endtask

   // longest intervals: nothing moves until a relative command forces steps
   task automatic test_forced_steps();
      set_config(8'd255, 8'd255, 8'd255, 1'b0);
      send_tick(make_tick(1'b1, 8'd100, 8'd50, 8'd100, 16'd1000, 1'b0, 1'b0));
      repeat (2) send_tick(idle_tick(1'b0, 1'b0));
      repeat (3) send_tick(idle_tick(1'b0, 1'b1));
      send_tick(idle_tick(1'b0, 1'b0));
      wait_idle();
   endtask

   // white channels drain the value in CCT mode; without them it follows the goal
   task automatic test_white_drain();
      set_config(8'd0, 8'd0, 8'd0, 1'b1);
      send_tick(make_tick(1'b1, 8'd40, 8'd10, 8'd10, 16'd3000, 1'b0, 1'b0));
      repeat (3) send_tick(idle_tick(1'b0, 1'b0));
      repeat (4) send_tick(idle_tick(1'b1, 1'b0));
      wait_idle();
      set_config(8'd0, 8'd0, 8'd0, 1'b0);
      repeat (3) send_tick(idle_tick(1'b1, 1'b0));
      wait_idle();
   endtask

   // receiver holds off while ticks keep coming, so the input stalls
   task automatic test_backpressure();
      set_config(8'd2, 8'd1, 8'd0, 1'b1);
      req_steady = 1'b1;
      rsp_hold   = PRESSURE_HOLD;
      repeat (30) send_tick(shaped_tick());
      req_steady = 1'b0;
      wait_idle();
   endtask

   // random ticks over a series of interval settings
   task automatic test_random_fades(input int phases, input int per_phase);
      bit [7:0] up, down, color;
      bit       white;
      for (int p = 0; p < phases; p++) begin
         case (p % 8)
            0: begin up = 8'd0;   down = 8'd0;   color = 8'd0;   white = 1'b0; end
            1: begin up = 8'd255; down = 8'd255; color = 8'd255; white = 1'b1; end
            2: begin up = 8'd1;   down = 8'd1;   color = 8'd1;   white = 1'b1; end
            3: begin up = 8'd0;   down = 8'd255; color = 8'd0;   white = 1'b0; end
            4: begin up = 8'd255; down = 8'd0;   color = 8'd1;   white = 1'b1; end
            default: begin
               up    = 8'($urandom_range(0, 6));
               down  = 8'($urandom_range(0, 6));
               color = 8'($urandom_range(0, 6));
               white = 1'($urandom_range(0, 1));
            end
         endcase
         set_config(up, down, color, white);
         req_steady = (p % 3) == 2;
         rsp_steady = (p % 4) == 3;
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 9) == 0) send_tick(random_tick());
            else send_tick(shaped_tick());
         end
         wait_idle();
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // result receiver: long hold, random gaps, or always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         if (rsp_tready && rsp_tvalid && !rsp_steady) rsp_gap = pick_gap();
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap = rsp_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string fname, input int want, input int got);
      if (want != got)
         note_failure($sformatf("%s mismatch: expected %0d, actual %0d", fname, want, got));
   endtask

   // compare each result transaction with the oldest expected state
   always @(posedge clock) begin : check_results
      fade_state_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fade_expect.size() == 0) begin
            note_failure($sformatf("result with nothing expected: %h", rsp_tdata));
         end else begin
            want = fade_expect.pop_front();
            check_field("level_now", int'(want.level), int'(rsp_tdata[7:0]));
            check_field("value_now", int'(want.value), int'(rsp_tdata[15:8]));
            check_field("hue_now", int'(want.hue), int'(rsp_tdata[23:16]));
            check_field("saturation_now", int'(want.sat), int'(rsp_tdata[31:24]));
            check_field("kelvin_now", int'(want.kelvin), int'(rsp_tdata[47:32]));
            check_field("drive_changed", int'(want.drive), int'(rsp_tdata[48]));
            check_field("onoff_changed", int'(want.onoff), int'(rsp_tdata[49]));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("led_fade_stepper_top verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_full_range();
      test_forced_steps();
      test_white_drain();
      test_backpressure();
      test_random_fades(8, 122);
      if (fail_count == 0 && fade_expect.size() == 0) begin
         $display("led_fade_stepper_top verification clean");
      end else begin
         $display("led_fade_stepper_top verification failed");
      end
      $finish;
   end

endmodule
